// ===== src/assert_macros.svh =====
// assertion macros shared by the ray parallelogram core
// no dependencies; SYNTH removes the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== src/rpi_pkg.sv =====
// package for the ray parallelogram core: widths, constants, helpers
// no dependencies
`timescale 1ns / 1ps
package rpi_pkg;
   localparam int CoordBits = 32;
   localparam int FracBits = 16;
   localparam int DirFrac = 19;
   localparam int CompBits = 21;
   localparam int DotBits = 56;
   // numerator of t scaled for the fraction bits
   localparam int NumBits = DotBits + 1;
   localparam int QBits = 34;
   localparam int DivSteps = NumBits + FracBits;
   localparam int DivStagesPer = 4;
   localparam int DivStages = (DivSteps + DivStagesPer - 1) / DivStagesPer;
   localparam logic [DotBits-1:0] EpsDt =
      DotBits'(((64'd1 << (FracBits + DirFrac)) + 64'd999999) / 64'd1000000);
   localparam logic signed [CoordBits-1:0] EpsT =
      CoordBits'((64'd1 << FracBits) / 64'd1000000);

   typedef enum logic [2:0] {
      REG_NORMAL = 3'd0, REG_UDIR = 3'd1, REG_VDIR = 3'd2, REG_DOFF = 3'd3,
      REG_UOFF = 3'd4, REG_VOFF = 3'd5, REG_LENU = 3'd6, REG_LENV = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [62:0] normal;
      logic [62:0] udir;
      logic [62:0] vdir;
      logic signed [31:0] doff;
      logic signed [31:0] uoff;
      logic signed [31:0] voff;
      logic [30:0] lenu;
      logic [30:0] lenv;
   } cfg_type;

   typedef struct packed {
      logic action;
      logic signed [31:0] ox, oy, oz;
      logic signed [31:0] dx, dy, dz;
      logic prior;
      logic [30:0] limit;
   } ray_type;

   function automatic logic signed [CompBits-1:0] comp(input logic [62:0] p,
                                                       input int k);
      comp = p[k*CompBits +: CompBits];
   endfunction
endpackage

// ===== src/rpi_stream_if.sv =====
// valid ready channel carrying one item of a given payload type
// depends on rpi_pkg only through the payload type
`timescale 1ns / 1ps
interface rpi_stream_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/rpi_div.sv =====
// pipelined restoring divider for t, one group of quotient bits per stage
// uses rpi_pkg
`timescale 1ns / 1ps
module rpi_div import rpi_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [NumBits-1:0] in_num,
   input  logic [DotBits-1:0] in_den,
   input  logic in_neg,
   input  ray_type in_ray,
   output logic out_valid,
   output logic signed [CoordBits-1:0] out_t,
   output ray_type out_ray
);
   localparam int RemBits = DotBits + 1;
   localparam int QW = DivSteps;
   logic v_ff [DivStages+1];
   logic [RemBits-1:0] r_ff [DivStages+1];
   logic [NumBits-1:0] n_ff [DivStages+1];
   logic [QW-1:0] q_ff [DivStages+1];
   logic [DotBits-1:0] d_ff [DivStages+1];
   logic neg_ff [DivStages+1];
   ray_type ray_ff [DivStages+1];

   assign v_ff[0] = in_valid;
   assign r_ff[0] = '0;
   assign n_ff[0] = in_num;
   assign q_ff[0] = '0;
   assign d_ff[0] = in_den;
   assign neg_ff[0] = in_neg;
   assign ray_ff[0] = in_ray;

   // each stage produces up to DivStagesPer quotient bits; the last takes the rest
   for (genvar s = 0; s < DivStages; s++) begin : g_st
      logic [RemBits-1:0] r_in;
      logic [NumBits-1:0] n_in;
      logic [QW-1:0] q_in;
      always_comb begin
         logic [RemBits:0] tr;
         r_in = r_ff[s];
         n_in = n_ff[s];
         q_in = q_ff[s];
         for (int i = 0; i < DivStagesPer; i++) begin
            if (s * DivStagesPer + i < DivSteps) begin
               tr = {r_in, n_in[NumBits-1]};
               n_in = {n_in[NumBits-2:0], 1'b0};
               if (tr >= {2'b00, d_ff[s]}) begin
                  tr = tr - {2'b00, d_ff[s]};
                  q_in = {q_in[QW-2:0], 1'b1};
               end else begin
                  q_in = {q_in[QW-2:0], 1'b0};
               end
               r_in = tr[RemBits-1:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else if (adv) v_ff[s+1] <= v_ff[s];
         if (adv) begin
            r_ff[s+1] <= r_in;
            n_ff[s+1] <= n_in;
            q_ff[s+1] <= q_in;
            d_ff[s+1] <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ray_ff[s+1] <= ray_ff[s];
         end
      end
   end

   // saturate: quotient magnitude, then sign
   logic [QW-1:0] q;
   logic big;
   assign q = q_ff[DivStages];
   assign big = |q[QW-1:CoordBits];
   always_comb begin
      if (neg_ff[DivStages]) begin
         if (big || q[CoordBits-1:0] > {1'b1, {(CoordBits-1){1'b0}}})
            out_t = {1'b1, {(CoordBits-1){1'b0}}};
         else
            out_t = -$signed(q[CoordBits-1:0]);
      end else begin
         if (big || q[CoordBits-1])
            out_t = {1'b0, {(CoordBits-1){1'b1}}};
         else
            out_t = $signed(q[CoordBits-1:0]);
      end
   end
   assign out_valid = v_ff[DivStages];
   assign out_ray = ray_ff[DivStages];
endmodule

// ===== src/ray_parallelogram_intersect_core.sv =====
// One ray per cycle is accepted while the result register is empty or taken.
// Throughput set by the fully pipelined 73-step divider (4 bits per stage),
// dot products and hit-point multiplies, each behind registers.
// The whole pipeline holds on a stall; nothing is lost or repeated.
// Synchronous active-high reset clears valid bits and all configuration.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ray_parallelogram_intersect_core import rpi_pkg::*; (
   input  logic clock,
   input  logic reset,
   rpi_stream_if.sink req,
   rpi_stream_if.source rsp,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [62:0] csr_wdata
);
   cfg_type cfg_ff;
   logic adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_NORMAL: cfg_ff.normal <= csr_wdata;
            REG_UDIR: cfg_ff.udir <= csr_wdata;
            REG_VDIR: cfg_ff.vdir <= csr_wdata;
            REG_DOFF: cfg_ff.doff <= csr_wdata[31:0];
            REG_UOFF: cfg_ff.uoff <= csr_wdata[31:0];
            REG_VOFF: cfg_ff.voff <= csr_wdata[31:0];
            REG_LENU: cfg_ff.lenu <= csr_wdata[30:0];
            REG_LENV: cfg_ff.lenv <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // output register with whole-pipe stall
   logic out_v_ff;
   assign adv = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // stage 1: products of normal with origin and dir
   logic s1_v_ff;
   ray_type s1_ray_ff;
   logic signed [52:0] s1_po_ff [3];
   logic signed [52:0] s1_pd_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req.valid;
      if (adv) begin
         s1_ray_ff <= req.data;
         s1_po_ff[0] <= comp(cfg_ff.normal, 0) * req.data.ox;
         s1_po_ff[1] <= comp(cfg_ff.normal, 1) * req.data.oy;
         s1_po_ff[2] <= comp(cfg_ff.normal, 2) * req.data.oz;
         s1_pd_ff[0] <= comp(cfg_ff.normal, 0) * req.data.dx;
         s1_pd_ff[1] <= comp(cfg_ff.normal, 1) * req.data.dy;
         s1_pd_ff[2] <= comp(cfg_ff.normal, 2) * req.data.dz;
      end
   end

   // stage 2: numerator, denominator, parallel check
   logic s2_v_ff, s2_par_ff, s2_neg_ff;
   ray_type s2_ray_ff;
   logic [NumBits-1:0] s2_num_ff;
   logic [DotBits-1:0] s2_den_ff;
   logic signed [NumBits:0] num_in;
   logic signed [DotBits-1:0] dt_in;
   always_comb begin
      dt_in = DotBits'(s1_pd_ff[0]) + DotBits'(s1_pd_ff[1]) + DotBits'(s1_pd_ff[2]);
      num_in = ((NumBits+1)'(cfg_ff.doff) <<< DirFrac)
             - (NumBits+1)'(s1_po_ff[0]) - (NumBits+1)'(s1_po_ff[1])
             - (NumBits+1)'(s1_po_ff[2]);
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv) begin
         s2_ray_ff <= s1_ray_ff;
         s2_par_ff <= (dt_in > -$signed(EpsDt)) && (dt_in < $signed(EpsDt));
         s2_neg_ff <= num_in[NumBits] ^ dt_in[DotBits-1];
         s2_num_ff <= num_in[NumBits] ? NumBits'(-num_in) : NumBits'(num_in);
         s2_den_ff <= dt_in[DotBits-1] ? DotBits'(-dt_in) : DotBits'(dt_in);
      end
   end

   // parallel flag travels beside the ray through the divider
   ray_type div_ray_in;
   always_comb begin
      div_ray_in = s2_ray_ff;
      div_ray_in.prior = s2_ray_ff.prior;
   end
   logic [DivStages-1:0] par_ff;
   always_ff @(posedge clock) begin
      if (adv) par_ff <= {par_ff[DivStages-2:0], s2_par_ff};
   end

   logic d_v;
   logic signed [CoordBits-1:0] d_t;
   ray_type d_ray;
   rpi_div u_div (
      .clock, .reset, .adv,
      .in_valid(s2_v_ff), .in_num(s2_num_ff),
      .in_den(s2_par_ff ? DotBits'(1) : s2_den_ff), .in_neg(s2_neg_ff),
      .in_ray(div_ray_in),
      .out_valid(d_v), .out_t(d_t), .out_ray(d_ray)
   );

   // stage 3: limits check and dir*t products
   logic s3_v_ff, s3_ok_ff;
   logic signed [CoordBits-1:0] s3_t_ff;
   logic signed [63:0] s3_p_ff [3];
   logic lim_fail;
   always_comb begin
      if (d_ray.action)
         lim_fail = (d_t <= EpsT) || (d_t > $signed({1'b0, d_ray.limit}));
      else
         lim_fail = d_ray.prior && (d_t > $signed({1'b0, d_ray.limit}));
   end
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (adv) s3_v_ff <= d_v;
      if (adv) begin
         s3_ok_ff <= !par_ff[DivStages-1] && !lim_fail;
         s3_t_ff <= d_t;
         s3_p_ff[0] <= (64'(d_ray.dx) * 64'(d_t)) + (64'(d_ray.ox) <<< FracBits);
         s3_p_ff[1] <= (64'(d_ray.dy) * 64'(d_t)) + (64'(d_ray.oy) <<< FracBits);
         s3_p_ff[2] <= (64'(d_ray.dz) * 64'(d_t)) + (64'(d_ray.oz) <<< FracBits);
      end
   end

   // stage 4: floor shift and saturate the hit point
   logic s4_v_ff, s4_ok_ff;
   logic signed [CoordBits-1:0] s4_t_ff;
   logic signed [CoordBits-1:0] s4_pt_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (adv) s4_v_ff <= s3_v_ff;
      if (adv) begin
         s4_ok_ff <= s3_ok_ff;
         s4_t_ff <= s3_t_ff;
         for (int k = 0; k < 3; k++) begin
            if (s3_p_ff[k] >>> FracBits > 64'sh7fffffff)
               s4_pt_ff[k] <= 32'sh7fffffff;
            else if (s3_p_ff[k] >>> FracBits < -64'sh80000000)
               s4_pt_ff[k] <= -32'sh80000000;
            else
               s4_pt_ff[k] <= s3_p_ff[k][FracBits +: CoordBits];
         end
      end
   end

   // stage 5: edge direction products
   logic s5_v_ff, s5_ok_ff;
   logic signed [CoordBits-1:0] s5_t_ff;
   logic signed [52:0] s5_u_ff [3];
   logic signed [52:0] s5_w_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (adv) s5_v_ff <= s4_v_ff;
      if (adv) begin
         s5_ok_ff <= s4_ok_ff;
         s5_t_ff <= s4_t_ff;
         for (int k = 0; k < 3; k++) begin
            s5_u_ff[k] <= comp(cfg_ff.udir, k) * s4_pt_ff[k];
            s5_w_ff[k] <= comp(cfg_ff.vdir, k) * s4_pt_ff[k];
         end
      end
   end

   // stage 6: bounds and result register
   logic signed [NumBits:0] au, av;
   logic hit_in;
   always_comb begin
      au = (NumBits+1)'(s5_u_ff[0]) + (NumBits+1)'(s5_u_ff[1])
         + (NumBits+1)'(s5_u_ff[2]) - ((NumBits+1)'(cfg_ff.uoff) <<< DirFrac);
      av = (NumBits+1)'(s5_w_ff[0]) + (NumBits+1)'(s5_w_ff[1])
         + (NumBits+1)'(s5_w_ff[2]) - ((NumBits+1)'(cfg_ff.voff) <<< DirFrac);
      hit_in = s5_ok_ff && !au[NumBits] && !av[NumBits]
         && au <= ((NumBits+1)'({1'b0, cfg_ff.lenu}) <<< DirFrac)
         && av <= ((NumBits+1)'({1'b0, cfg_ff.lenv}) <<< DirFrac);
   end
   logic out_hit_ff;
   logic signed [CoordBits-1:0] out_t_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= s5_v_ff;
      if (adv) begin
         out_hit_ff <= hit_in;
         out_t_ff <= hit_in ? s5_t_ff : '0;
      end
   end
   assign rsp.valid = out_v_ff;
   assign rsp.data.hit = out_hit_ff;
   assign rsp.data.hit_t = out_t_ff;

   `ASSERT_IMPLIES(a_stall_ready, clock, reset, out_v_ff && !rsp.ready, !req.ready)
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, out_v_ff && !out_hit_ff, out_t_ff == '0)
   `ASSERT_NEXT(a_hold, clock, reset, out_v_ff && !rsp.ready, out_v_ff && $stable(out_t_ff))
endmodule
